// ----- design/rhh_pkg.sv -----
// ----------------------------------------------------------------------------
// rhh_pkg: shared types and constants for the Robin Hood hash table
// Request and response beats, request and status codes, FNV-1a constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rhh_pkg;

    localparam logic [1:0] REQ_SEARCH  = 2'd0;
    localparam logic [1:0] REQ_INSERT  = 2'd1;
    localparam logic [1:0] REQ_REMOVE  = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_EXISTS    = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_MULT  = 32'd16777619;

    localparam int CFG_W = 11;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
    } rsp_t;

endpackage

`default_nettype wire

// ----- design/robin_hood_hash_table.sv -----
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Open-addressing key/value table, linear probing with Robin Hood
// displacement and backward-shift removal, driven by one small sequencer.
// ----------------------------------------------------------------------------
//  channel  | ports                         | payload
//  request  | s_valid, s_ready, s_data      | rhh_pkg::req_t
//  response | m_valid, m_ready, m_data      | rhh_pkg::rsp_t
//  config   | cfg_wr_en, cfg_wr_data        | max_entries, 11 bits
//
//  Each request runs through: accept, one hash multiply round per key byte,
//  the home slot remainder by reciprocal multiply on the same multiplier, a
//  read and a check for each slot probed and for each slot visited by an
//  insert or a backward shift, then the response hand-off. The single read
//  port of the slot memory, which is registered, sets the probe cost.
//  After reset a clearing pass over every slot runs before s_ready rises.
//  A waiting response does not block the next request; only the hand-off
//  waits for the response register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module robin_hood_hash_table #(
    parameter int TABLE_SIZE = 1024,
    parameter int KEY_BYTES  = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire rhh_pkg::req_t              s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output rhh_pkg::rsp_t                   m_data,
    input  wire logic                       cfg_wr_en,
    input  wire logic [rhh_pkg::CFG_W-1:0]  cfg_wr_data
);

    localparam int AW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int IW  = $clog2(TABLE_SIZE + 1);
    localparam int HCW = $clog2(KEY_BYTES + 1);
    localparam int EW  = 1 + IW + 64;
    localparam int SH  = $clog2(TABLE_SIZE);

    // floor(2^(32+SH) / TABLE_SIZE) + 1 gives an exact quotient for any
    // 32-bit hash; its top bit (2^32) is folded in as an add
    localparam logic [63:0] RECIP    = ((64'd1 << (32 + SH)) / 64'(TABLE_SIZE)) + 64'd1;
    localparam logic [31:0] RECIP_LO = RECIP[31:0];

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_HASH  = 4'd2;
    localparam logic [3:0] ST_MOD1  = 4'd3;
    localparam logic [3:0] ST_MOD2  = 4'd4;
    localparam logic [3:0] ST_MOD3  = 4'd5;
    localparam logic [3:0] ST_LRD   = 4'd6;
    localparam logic [3:0] ST_LCHK  = 4'd7;
    localparam logic [3:0] ST_IRD   = 4'd8;
    localparam logic [3:0] ST_ICHK  = 4'd9;
    localparam logic [3:0] ST_RRD   = 4'd10;
    localparam logic [3:0] ST_RCHK  = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);
    localparam logic [IW-1:0] LAST_STEP = IW'(TABLE_SIZE - 1);

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
        return (a == LAST_SLOT) ? '0 : a + 1'b1;
    endfunction

    logic [3:0]              state_reg, state_next;
    rhh_pkg::req_t           req_reg, req_next;
    logic [31:0]             hash_reg, hash_next;
    logic [HCW-1:0]          hcnt_reg, hcnt_next;
    logic [63:0]             prod_reg, prod_next;
    logic [31:0]             quo_reg, quo_next;
    logic [AW-1:0]           home_reg, home_next;
    logic [AW-1:0]           slot_reg, slot_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic [IW-1:0]           step_reg, step_next;
    logic [31:0]             ck_reg, ck_next;
    logic [31:0]             cv_reg, cv_next;
    logic [IW-1:0]           cd_reg, cd_next;
    logic [IW-1:0]           live_reg, live_next;
    logic [rhh_pkg::CFG_W-1:0] max_reg, max_next;
    logic [AW-1:0]           clr_reg, clr_next;
    rhh_pkg::rsp_t           rsp_reg, rsp_next;
    rhh_pkg::rsp_t           out_reg, out_next;
    logic                    mval_reg, mval_next;

    logic [EW-1:0]           mem [TABLE_SIZE];
    logic [EW-1:0]           rdata_reg;
    logic                    mem_we;
    logic [AW-1:0]           mem_wa;
    logic [EW-1:0]           mem_wd;

    logic                    rd_used;
    logic [IW-1:0]           rd_dist;
    logic [31:0]             rd_key;
    logic [31:0]             rd_val;
    logic [7:0]              hbyte;
    logic [31:0]             hmix;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             mul_p;
    logic [31:0]             home_full;
    logic [31:0]             limit;
    logic                    at_limit;

    assign rd_used = rdata_reg[EW-1];
    assign rd_dist = rdata_reg[EW-2 -: IW];
    assign rd_key  = rdata_reg[63:32];
    assign rd_val  = rdata_reg[31:0];

    // bytes past the fourth shift out to zero
    assign hbyte = 8'(req_reg.key >> {hcnt_reg, 3'b000});
    assign hmix  = hash_reg ^ {24'd0, hbyte};

    // one multiplier serves the hash rounds and the home slot reduction
    always_comb begin
        unique case (state_reg)
            ST_MOD1: begin
                mul_a = hash_reg;
                mul_b = RECIP_LO;
            end
            ST_MOD3: begin
                mul_a = quo_reg;
                mul_b = 32'(TABLE_SIZE);
            end
            default: begin
                mul_a = hmix;
                mul_b = rhh_pkg::FNV_MULT;
            end
        endcase
    end

    assign mul_p     = 64'(mul_a) * 64'(mul_b);
    assign home_full = hash_reg - mul_p[31:0];

    assign limit    = (32'(max_reg) < 32'(TABLE_SIZE)) ? 32'(max_reg) : 32'(TABLE_SIZE);
    assign at_limit = (32'(live_reg) + 32'd1) > limit;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mval_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        hash_next  = hash_reg;
        hcnt_next  = hcnt_reg;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        home_next  = home_reg;
        slot_next  = slot_reg;
        cur_next   = cur_reg;
        step_next  = step_reg;
        ck_next    = ck_reg;
        cv_next    = cv_reg;
        cd_next    = cd_reg;
        live_next  = live_reg;
        max_next   = cfg_wr_en ? cfg_wr_data : max_reg;
        clr_next   = clr_reg;
        rsp_next   = rsp_reg;
        out_next   = out_reg;
        mval_next  = (mval_reg && m_ready) ? 1'b0 : mval_reg;
        mem_we     = 1'b0;
        mem_wa     = slot_reg;
        mem_wd     = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    hash_next  = rhh_pkg::FNV_BASIS;
                    hcnt_next  = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                hash_next = mul_p[31:0];
                hcnt_next = hcnt_reg + 1'b1;
                if (hcnt_reg == HCW'(KEY_BYTES - 1)) begin
                    state_next = ST_MOD1;
                end
            end
            ST_MOD1: begin
                prod_next  = mul_p;
                state_next = ST_MOD2;
            end
            ST_MOD2: begin
                quo_next   = 32'((33'(hash_reg) + 33'(prod_reg[63:32])) >> SH);
                state_next = ST_MOD3;
            end
            ST_MOD3: begin
                home_next = AW'(home_full);
                slot_next = AW'(home_full);
                step_next = '0;
                rsp_next  = '{status: rhh_pkg::STATUS_NOT_FOUND, found_value: 32'd0};
                if (req_reg.req_type == rhh_pkg::REQ_SEARCH ||
                    req_reg.req_type == rhh_pkg::REQ_INSERT ||
                    req_reg.req_type == rhh_pkg::REQ_REMOVE) begin
                    state_next = ST_LRD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LRD: begin
                state_next = ST_LCHK;
            end
            ST_LCHK: begin
                if (rd_used && rd_key == req_reg.key) begin
                    case (req_reg.req_type)
                        rhh_pkg::REQ_SEARCH: begin
                            rsp_next   = '{status: rhh_pkg::STATUS_OK, found_value: rd_val};
                            state_next = ST_DONE;
                        end
                        rhh_pkg::REQ_INSERT: begin
                            rsp_next.status = rhh_pkg::STATUS_EXISTS;
                            state_next      = ST_DONE;
                        end
                        default: begin
                            cur_next   = slot_reg;
                            slot_next  = slot_inc(slot_reg);
                            step_next  = '0;
                            state_next = ST_RRD;
                        end
                    endcase
                end else if (rd_used && !(rd_dist < step_reg) && step_reg != LAST_STEP) begin
                    step_next  = step_reg + 1'b1;
                    slot_next  = slot_inc(slot_reg);
                    state_next = ST_LRD;
                end else if (req_reg.req_type == rhh_pkg::REQ_INSERT) begin
                    if (at_limit) begin
                        rsp_next.status = rhh_pkg::STATUS_FULL;
                        state_next      = ST_DONE;
                    end else begin
                        slot_next  = home_reg;
                        step_next  = '0;
                        ck_next    = req_reg.key;
                        cv_next    = req_reg.value;
                        cd_next    = '0;
                        state_next = ST_IRD;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_IRD: begin
                state_next = ST_ICHK;
            end
            ST_ICHK: begin
                if (!rd_used) begin
                    mem_we          = 1'b1;
                    mem_wd          = {1'b1, cd_reg, ck_reg, cv_reg};
                    live_next       = live_reg + 1'b1;
                    rsp_next.status = rhh_pkg::STATUS_OK;
                    state_next      = ST_DONE;
                end else begin
                    // swap the carried entry with a richer resident
                    if (cd_reg > rd_dist) begin
                        mem_we  = 1'b1;
                        mem_wd  = {1'b1, cd_reg, ck_reg, cv_reg};
                        ck_next = rd_key;
                        cv_next = rd_val;
                        cd_next = rd_dist + 1'b1;
                    end else begin
                        cd_next = cd_reg + 1'b1;
                    end
                    step_next = step_reg + 1'b1;
                    slot_next = slot_inc(slot_reg);
                    if (step_reg == LAST_STEP) begin
                        rsp_next.status = rhh_pkg::STATUS_FULL;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_IRD;
                    end
                end
            end
            ST_RRD: begin
                state_next = ST_RCHK;
            end
            ST_RCHK: begin
                mem_we = 1'b1;
                mem_wa = cur_reg;
                if (step_reg == LAST_STEP || !rd_used || rd_dist == '0) begin
                    mem_wd          = '0;
                    live_next       = (live_reg != '0) ? live_reg - 1'b1 : live_reg;
                    rsp_next.status = rhh_pkg::STATUS_OK;
                    state_next      = ST_DONE;
                end else begin
                    // pull the follower back one slot
                    mem_wd     = {1'b1, rd_dist - 1'b1, rd_key, rd_val};
                    cur_next   = slot_reg;
                    slot_next  = slot_inc(slot_reg);
                    step_next  = step_reg + 1'b1;
                    state_next = ST_RRD;
                end
            end
            ST_DONE: begin
                if (!mval_reg || m_ready) begin
                    out_next   = rsp_reg;
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            live_reg  <= '0;
            max_reg   <= rhh_pkg::CFG_W'(1024);
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            live_reg  <= live_next;
            max_reg   <= max_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        hash_reg <= hash_next;
        hcnt_reg <= hcnt_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        home_reg <= home_next;
        slot_reg <= slot_next;
        cur_reg  <= cur_next;
        step_reg <= step_next;
        ck_reg   <= ck_next;
        cv_reg   <= cv_next;
        cd_reg   <= cd_next;
        rsp_reg  <= rsp_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[slot_reg];
    end

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(live_reg) <= 32'(TABLE_SIZE))
        else $error("live count beyond table size");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while busy");

    a_value_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != rhh_pkg::STATUS_OK) |-> (m_data.found_value == 32'd0))
        else $error("value on a miss");

    a_live_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (live_reg != $past(live_reg)) |-> $past(state_reg == ST_ICHK ||
        state_reg == ST_RCHK))
        else $error("live count moved outside insert or remove");

endmodule

`default_nettype wire
